[rtl/binary_erosion_2x2_core_defines.svh]
// Assertion macros shared by the erosion core.
// Each use expands to one labeled concurrent assertion clocked on clk,
// switched off while rst_n is low.
`ifndef BINARY_EROSION_2X2_CORE_DEFINES_SVH
`define BINARY_EROSION_2X2_CORE_DEFINES_SVH

// A condition that holds at every clock edge.
`define BE2X2_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that holds at the same edge as its cause.
`define BE2X2_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds at the edge after its cause.
`define BE2X2_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/be2x2_pkg.sv]
package be2x2_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int LEVEL_W   = 8;
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam logic [LEVEL_W-1:0] LEVEL_ON = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Per-item control carried from the address stage to the window stage.
  typedef struct packed {
    logic pix;
    logic emit;
    logic last;
    logic gate;
    logic cur;
    logic restart;
  } be_ctl_t;

endpackage

[rtl/binary_erosion_2x2_core.sv]
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_kind, in_red_level
// out      output     out_valid/out_stall out_level, out_frame_last
// cfg      input      cfg_we              cfg_index, cfg_wdata
//
// One item is taken every cycle while in_stall is low.
// The line store is one memory with a read and a write each cycle; in a
// one-pixel-wide frame the same entry is read and written back to back and
// the written value is forwarded.
// Reset restores the configuration, counters, valid and window flags;
// the line store is not cleared, since an entry is always written in the
// row before it can reach a result. A held result under out_stall freezes
// the whole pipeline and raises in_stall in the same cycle.
`include "binary_erosion_2x2_core_defines.svh"

module binary_erosion_2x2_core #(
  parameter int MAX_WIDTH = be2x2_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [be2x2_pkg::LEVEL_W-1:0]  in_red_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [be2x2_pkg::LEVEL_W-1:0]  out_level,
  output logic                           out_frame_last,
  input  logic                           cfg_we,
  input  logic [be2x2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [be2x2_pkg::CFG_W-1:0]    cfg_wdata
);

  import be2x2_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = HGT_W;
  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int EW = (WW > CFG_W) ? WW : CFG_W;
  localparam int W_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int TOTAL_M1_RST = W_RST_EFF * HEIGHT_RST - 1;

  function automatic logic [WW-1:0] eff_width(input logic [CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) return WW'(1);
    if (ve > EW'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(ve);
  endfunction

  function automatic logic [HW-1:0] eff_height(input logic [CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) return HW'(1);
    if (ve > EW'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return HW'(ve);
  endfunction

  // Configuration and frame counters.
  logic [WW-1:0]      w_eff_r, w_eff_nxt;
  logic [HW-1:0]      h_eff_r, h_eff_nxt;
  logic [PW-1:0]      total_m1_r, total_m1_nxt;
  logic [AW-1:0]      col_r, col_nxt;
  logic [HW-1:0]      row_r, row_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               cfg_restart;
  logic [WW+HW-1:0]   cfg_prod;

  // Window stage and output register.
  logic               b_valid_r;
  be_ctl_t            b_ctl_r;
  logic [AW-1:0]      b_addr_r;
  logic               left_r;
  logic               ul_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_last_r;

  logic               adv;
  logic               acc;
  logic               row_full;
  logic               col_last;
  logic               is_last_pos;
  logic               col_ge1;
  logic               pix_emit;
  logic               pix_keep;
  logic               flush_keep;
  be_ctl_t            a_ctl;
  logic               above;
  logic               level_on;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  always_comb begin
    w_eff_nxt   = w_eff_r;
    h_eff_nxt   = h_eff_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH: begin
          w_eff_nxt   = eff_width(cfg_wdata);
          cfg_restart = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          h_eff_nxt   = eff_height(cfg_wdata);
          cfg_restart = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
    cfg_prod     = (WW+HW)'(w_eff_nxt) * (WW+HW)'(h_eff_nxt);
    total_m1_nxt = PW'(cfg_prod - (WW+HW)'(1));
  end

  assign row_full    = row_r >= h_eff_r;
  assign col_last    = (WW'(col_r) + WW'(1)) == w_eff_r;
  assign is_last_pos = pos_r == total_m1_r;
  assign col_ge1     = col_r != '0;
  assign pix_emit    = (row_r >= HW'(2)) || ((row_r == HW'(1)) && col_ge1);
  assign pix_keep    = !in_kind && !row_full;
  // A flush counts only once the frame is in and outputs remain.
  assign flush_keep  = in_kind && row_full && (pos_r <= total_m1_r);

  always_comb begin
    a_ctl.pix     = !in_kind;
    a_ctl.emit    = in_kind || pix_emit;
    a_ctl.last    = (in_kind || pix_emit) && is_last_pos;
    a_ctl.gate    = (row_r != '0) && col_ge1;
    a_ctl.cur     = |in_red_level;
    a_ctl.restart = in_kind && is_last_pos;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    if (cfg_restart) begin
      col_nxt = '0;
      row_nxt = '0;
      pos_nxt = '0;
    end else if (acc && pix_keep) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + HW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
      if (pix_emit) begin
        pos_nxt = pos_r + PW'(1);
      end
    end else if (acc && flush_keep) begin
      if (is_last_pos) begin
        col_nxt = '0;
        row_nxt = '0;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r    <= WW'(W_RST_EFF);
      h_eff_r    <= HW'(HEIGHT_RST);
      total_m1_r <= PW'(TOTAL_M1_RST);
      col_r      <= '0;
      row_r      <= '0;
      pos_r      <= '0;
    end else begin
      w_eff_r    <= w_eff_nxt;
      h_eff_r    <= h_eff_nxt;
      if (cfg_restart) begin
        total_m1_r <= total_m1_nxt;
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pos_r      <= pos_nxt;
    end
  end

  be2x2_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rd_en   (acc && pix_keep),
    .rd_addr (col_r),
    .wr_en   (b_valid_r && b_ctl_r.pix),
    .wr_addr (b_addr_r),
    .wr_data (b_ctl_r.cur),
    .above   (above)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl_r  <= a_ctl;
      b_addr_r <= col_r;
    end
  end

  assign level_on = b_ctl_r.pix && b_ctl_r.gate && b_ctl_r.cur && above && left_r && ul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      left_r      <= 1'b0;
      ul_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        b_valid_r   <= acc && (pix_keep || flush_keep);
        out_valid_r <= b_valid_r && b_ctl_r.emit;
      end
      if (cfg_restart || (adv && b_valid_r && b_ctl_r.restart)) begin
        left_r <= 1'b0;
        ul_r   <= 1'b0;
      end else if (adv && b_valid_r && b_ctl_r.pix) begin
        left_r <= b_ctl_r.cur;
        ul_r   <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r <= level_on ? LEVEL_ON : '0;
      out_last_r  <= b_ctl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_frame_last = out_last_r;

  `BE2X2_IMPLY(a_level_code, out_valid_r, (out_level_r == LEVEL_ON) || (out_level_r == '0), "result level is neither 0 nor 255")
  `BE2X2_CHECK(a_row_bound, row_r <= h_eff_r, "row counter ran past the frame height")
  `BE2X2_CHECK(a_pos_bound, pos_r <= total_m1_r, "output position ran past the frame")
  `BE2X2_IMPLY_NEXT(a_stall_hold, b_valid_r && !adv, b_valid_r && $stable(b_addr_r), "window stage moved while stalled")
  `BE2X2_IMPLY(a_last_zero, out_valid_r && out_last_r, out_level_r == '0, "last output of a frame is not zero")

endmodule

[rtl/be2x2_line_buf.sv]
module be2x2_line_buf #(
  parameter int DEPTH = be2x2_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  output logic          above
);

  logic mem [DEPTH];
  logic rd_q_r;
  logic fwd_r;
  logic fwd_d_r;

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rd_en) begin
      rd_q_r  <= mem[rd_addr];
      fwd_d_r <= wr_data;
    end
  end

  // The array reads old data when the same entry is written in that cycle,
  // so the write value is kept aside and substituted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (adv && rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign above = fwd_r ? fwd_d_r : rd_q_r;

endmodule
